// ===== rtl/assert_macros.svh =====
// assertion helpers used by the top level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next cycle check failed");

// expression holds on every rising clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant check failed");

`endif

// ===== rtl/sfs_pkg.sv =====
// shared types and constants of the symbol frequency sorter
// no dependencies
`timescale 1ns / 1ps

package sfs_pkg;

   // request opcodes
   localparam logic [1:0] OP_COUNT = 2'd0;
   localparam logic [1:0] OP_SORT  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_RANGE    = 2'd1;
   localparam logic [1:0] ST_UNSORTED = 2'd2;

   // which fields the response register is loaded with
   typedef enum logic [2:0] {
      RK_ZERO,
      RK_COUNT,
      RK_SKIP,
      RK_UNSORT,
      RK_RANGE,
      RK_READ
   } rsp_kind_type;

   // controller to datapath commands
   typedef struct packed {
      logic         capture;
      logic         cnt_rd_req;
      logic         cnt_upd;
      logic         clr;
      logic         ord_rd;
      logic         cnt_rd_ord;
      logic         scan_init;
      logic         scan_step;
      logic         scan_commit;
      logic         set_sorted;
      logic         load_rsp;
      rsp_kind_type kind;
   } sfs_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [1:0] op;
      logic       sym_ok;
      logic       order_valid;
      logic       rank_ok;
      logic       none_distinct;
      logic       scan_end;
      logic       more;
   } sfs_stat_type;

endpackage

// ===== rtl/sfs_ctrl.sv =====
// controller state machine of the symbol frequency sorter
// depends on sfs_pkg
`timescale 1ns / 1ps

module sfs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sfs_pkg::sfs_stat_type stat,
   output sfs_pkg::sfs_cmd_type  cmd
);
   import sfs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISP,
      S_CUPD,
      S_OCNT,
      S_SCAN,
      S_SCOM,
      S_RESP
   } state_type;

   state_type    state_ff;
   rsp_kind_type kind_ff;
   logic         rsp_valid_ff;
   logic         load;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign load      = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   // commands decoded from state and status
   always_comb begin
      cmd             = '0;
      cmd.kind        = kind_ff;
      cmd.capture     = (state_ff == S_IDLE) && req_valid;
      cmd.load_rsp    = load;
      cmd.cnt_upd     = (state_ff == S_CUPD);
      cmd.cnt_rd_ord  = (state_ff == S_OCNT);
      cmd.scan_step   = (state_ff == S_SCAN) && !stat.scan_end;
      cmd.scan_commit = (state_ff == S_SCOM);
      if (state_ff == S_SCOM && !stat.more) begin
         cmd.set_sorted = 1'b1;
      end
      if (state_ff == S_DISP) begin
         case (stat.op)
            OP_COUNT: cmd.cnt_rd_req = stat.sym_ok;
            OP_SORT: begin
               cmd.set_sorted = stat.none_distinct;
               cmd.scan_init  = !stat.none_distinct;
            end
            OP_READ: cmd.ord_rd = stat.order_valid && stat.rank_ok;
            default: cmd.clr = 1'b1;
         endcase
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= RK_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DISP;
               end
            end
            S_DISP: begin
               case (stat.op)
                  OP_COUNT: begin
                     if (stat.sym_ok) begin
                        state_ff <= S_CUPD;
                     end else begin
                        kind_ff  <= RK_SKIP;
                        state_ff <= S_RESP;
                     end
                  end
                  OP_SORT: begin
                     if (stat.none_distinct) begin
                        kind_ff  <= RK_ZERO;
                        state_ff <= S_RESP;
                     end else begin
                        state_ff <= S_SCAN;
                     end
                  end
                  OP_READ: begin
                     if (!stat.order_valid) begin
                        kind_ff  <= RK_UNSORT;
                        state_ff <= S_RESP;
                     end else if (!stat.rank_ok) begin
                        kind_ff  <= RK_RANGE;
                        state_ff <= S_RESP;
                     end else begin
                        state_ff <= S_OCNT;
                     end
                  end
                  default: begin
                     kind_ff  <= RK_ZERO;
                     state_ff <= S_RESP;
                  end
               endcase
            end
            S_CUPD: begin
               kind_ff  <= RK_COUNT;
               state_ff <= S_RESP;
            end
            S_OCNT: begin
               kind_ff  <= RK_READ;
               state_ff <= S_RESP;
            end
            S_SCAN: begin
               if (stat.scan_end) begin
                  state_ff <= S_SCOM;
               end
            end
            S_SCOM: begin
               if (stat.more) begin
                  state_ff <= S_SCAN;
               end else begin
                  kind_ff  <= RK_ZERO;
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/sfs_datapath.sv =====
// count table, sorted order memory, scan unit and response register
// depends on sfs_pkg
`timescale 1ns / 1ps

module sfs_datapath #(
   parameter int ALPHABET_SIZE = 128,
   parameter int COUNT_BITS    = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_opcode,
   input  logic [7:0]            req_symbol,
   input  logic [6:0]            req_rank,
   input  sfs_pkg::sfs_cmd_type  cmd,
   output sfs_pkg::sfs_stat_type stat,
   output logic [1:0]            rsp_status,
   output logic [6:0]            rsp_ranked_symbol,
   output logic [31:0]           rsp_symbol_count,
   output logic [31:0]           rsp_total_count,
   output logic [7:0]            rsp_distinct_symbols
);
   import sfs_pkg::*;

   localparam int SYM_W = $clog2(ALPHABET_SIZE);
   localparam int IDX_W = $clog2(ALPHABET_SIZE + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // captured transaction
   logic [1:0] op_ff;
   logic [6:0] sym_ff;
   logic [6:0] rank_ff;

   // memories and their read registers
   logic [COUNT_BITS-1:0] count_mem [ALPHABET_SIZE];
   logic [SYM_W-1:0]      ord_mem [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] valid_ff;
   logic [COUNT_BITS-1:0] cnt_q_ff;
   logic                  cval_q_ff;
   logic [SYM_W-1:0]      ord_q_ff;

   // totals
   logic [COUNT_BITS-1:0] total_ff;
   logic [IDX_W-1:0]      nonzero_ff;
   logic                  order_valid_ff;
   logic [COUNT_BITS-1:0] upd_cnt_ff;

   // scan unit
   logic [IDX_W-1:0]      idx_ff;
   logic                  pv_ff;
   logic [SYM_W-1:0]      psym_ff;
   logic                  best_v_ff;
   logic [COUNT_BITS-1:0] best_cnt_ff;
   logic [SYM_W-1:0]      best_sym_ff;
   logic [COUNT_BITS-1:0] last_cnt_ff;
   logic [SYM_W-1:0]      last_sym_ff;
   logic [SYM_W-1:0]      srank_ff;

   // response register
   logic [1:0]            status_ff;
   logic [6:0]            rsym_ff;
   logic [31:0]           rcnt_ff;

   logic [8:0]            sym9;
   logic [8:0]            rank9;
   logic [SYM_W-1:0]      req_idx;
   logic [SYM_W-1:0]      rank_idx;
   logic [SYM_W-1:0]      rd_addr;
   logic                  rd_en;
   logic [COUNT_BITS-1:0] eff_cnt;
   logic [COUNT_BITS-1:0] new_cnt;
   logic                  take;
   logic [8:0]            ord9;
   logic [63:0]           eff64;
   logic [63:0]           upd64;
   logic [63:0]           tot64;
   logic [8:0]            dist9;

   assign sym9     = {2'b00, sym_ff};
   assign rank9    = {2'b00, rank_ff};
   assign req_idx  = sym9[SYM_W-1:0];
   assign rank_idx = rank9[SYM_W-1:0];
   assign ord9     = 9'(ord_q_ff);
   assign eff_cnt  = cval_q_ff ? cnt_q_ff : '0;
   assign new_cnt  = (eff_cnt == COUNT_MAX) ? eff_cnt : eff_cnt + 1'b1;
   assign eff64    = 64'(eff_cnt);
   assign upd64    = 64'(upd_cnt_ff);
   assign tot64    = 64'(total_ff);
   assign dist9    = 9'(nonzero_ff);

   // status to the controller
   always_comb begin
      stat               = '0;
      stat.op            = op_ff;
      stat.sym_ok        = sym9 < 9'(ALPHABET_SIZE);
      stat.order_valid   = order_valid_ff;
      stat.rank_ok       = rank9 < dist9;
      stat.none_distinct = (nonzero_ff == '0);
      stat.scan_end      = (idx_ff == IDX_W'(ALPHABET_SIZE)) && !pv_ff;
      stat.more          = (10'(srank_ff) + 10'd1) < 10'(nonzero_ff);
   end

   // count memory read port address
   always_comb begin
      if (cmd.scan_step) begin
         rd_addr = idx_ff[SYM_W-1:0];
      end else if (cmd.cnt_rd_ord) begin
         rd_addr = ord_q_ff;
      end else begin
         rd_addr = req_idx;
      end
      rd_en = cmd.cnt_rd_req || cmd.cnt_rd_ord ||
              (cmd.scan_step && (idx_ff < IDX_W'(ALPHABET_SIZE)));
   end

   // candidate is the smallest key above the last ranked one
   always_comb begin
      take = pv_ff && (eff_cnt != '0) &&
             ((eff_cnt > last_cnt_ff) ||
              ((eff_cnt == last_cnt_ff) && (psym_ff > last_sym_ff))) &&
             (!best_v_ff || (eff_cnt < best_cnt_ff));
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.cnt_upd) begin
         count_mem[req_idx] <= new_cnt;
      end
      if (rd_en) begin
         cnt_q_ff <= count_mem[rd_addr];
      end
      if (cmd.scan_commit) begin
         ord_mem[srank_ff] <= best_sym_ff;
      end
      if (cmd.ord_rd) begin
         ord_q_ff <= ord_mem[rank_idx];
      end
   end

   // valid bits stand in for the zeroed table
   always_ff @(posedge clock) begin
      if (reset || cmd.clr) begin
         valid_ff  <= '0;
         cval_q_ff <= 1'b0;
      end else begin
         if (cmd.cnt_upd) begin
            valid_ff[req_idx] <= 1'b1;
         end
         if (rd_en) begin
            cval_q_ff <= valid_ff[rd_addr];
         end
      end
   end

   // totals and order flag
   always_ff @(posedge clock) begin
      if (reset || cmd.clr) begin
         total_ff       <= '0;
         nonzero_ff     <= '0;
         order_valid_ff <= 1'b0;
      end else begin
         if (cmd.cnt_upd) begin
            if (total_ff != COUNT_MAX) begin
               total_ff <= total_ff + 1'b1;
            end
            if (eff_cnt == '0) begin
               nonzero_ff <= nonzero_ff + 1'b1;
            end
            order_valid_ff <= 1'b0;
         end else if (cmd.set_sorted) begin
            order_valid_ff <= 1'b1;
         end
      end
   end

   // transaction capture and count update result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         sym_ff  <= req_symbol[6:0];
         rank_ff <= req_rank;
      end
      if (cmd.cnt_upd) begin
         upd_cnt_ff <= new_cnt;
      end
   end

   // scan unit: one table entry per cycle
   always_ff @(posedge clock) begin
      if (cmd.scan_init || cmd.scan_commit) begin
         idx_ff    <= '0;
         pv_ff     <= 1'b0;
         best_v_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (idx_ff < IDX_W'(ALPHABET_SIZE)) begin
            idx_ff  <= idx_ff + 1'b1;
            pv_ff   <= 1'b1;
            psym_ff <= idx_ff[SYM_W-1:0];
         end else begin
            pv_ff <= 1'b0;
         end
         if (take) begin
            best_v_ff   <= 1'b1;
            best_cnt_ff <= eff_cnt;
            best_sym_ff <= psym_ff;
         end
      end
      if (cmd.scan_init) begin
         srank_ff    <= '0;
         last_cnt_ff <= '0;
         last_sym_ff <= '0;
      end else if (cmd.scan_commit) begin
         srank_ff    <= srank_ff + 1'b1;
         last_cnt_ff <= best_cnt_ff;
         last_sym_ff <= best_sym_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff <= ST_OK;
         rsym_ff   <= '0;
         rcnt_ff   <= '0;
         case (cmd.kind)
            RK_COUNT: begin
               rsym_ff <= sym_ff;
               rcnt_ff <= upd64[31:0];
            end
            RK_SKIP:   rsym_ff   <= sym_ff;
            RK_UNSORT: status_ff <= ST_UNSORTED;
            RK_RANGE:  status_ff <= ST_RANGE;
            RK_READ: begin
               rsym_ff <= ord9[6:0];
               rcnt_ff <= eff64[31:0];
            end
            default: status_ff <= ST_OK;
         endcase
         rsp_total_count      <= tot64[31:0];
         rsp_distinct_symbols <= dist9[7:0];
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_ranked_symbol = rsym_ff;
   assign rsp_symbol_count  = rcnt_ff;

endmodule

// ===== rtl/symbol_frequency_sorter_unit.sv =====
// top level of the symbol frequency sorter
// depends on sfs_pkg, sfs_ctrl, sfs_datapath and assert_macros.svh
`timescale 1ns / 1ps

// Histogram and frequency sort front end for a Huffman coder. One response
// per request. The block takes the next request as soon as the response
// is loaded, while it still waits on rsp_ready. A sort request scans the
// count memory through its single read port one entry per cycle, once per
// distinct symbol. Counts live in a memory whose entries are marked empty
// by a bank of valid bits, so reset and clear are immediate.

`include "assert_macros.svh"

module symbol_frequency_sorter_unit #(
   parameter int ALPHABET_SIZE = 128,
   parameter int COUNT_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_symbol,
   input  logic [6:0]  req_rank,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_ranked_symbol,
   output logic [31:0] rsp_symbol_count,
   output logic [31:0] rsp_total_count,
   output logic [7:0]  rsp_distinct_symbols
);
   import sfs_pkg::*;

   sfs_cmd_type  cmd;
   sfs_stat_type stat;

   // sequencing
   sfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and arithmetic
   sfs_datapath #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .COUNT_BITS    (COUNT_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_opcode           (req_opcode),
      .req_symbol           (req_symbol),
      .req_rank             (req_rank),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_status           (rsp_status),
      .rsp_ranked_symbol    (rsp_ranked_symbol),
      .rsp_symbol_count     (rsp_symbol_count),
      .rsp_total_count      (rsp_total_count),
      .rsp_distinct_symbols (rsp_distinct_symbols)
   );

   // an accepted transaction makes the block busy
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // response register is never overwritten while still pending
   `ASSERT_IMPLY(a_no_overwrite, clock, reset, cmd.load_rsp, !rsp_valid || rsp_ready)
   // count memory read address has one source at a time
   `ASSERT_ALWAYS(a_one_rd_src, clock, reset, $onehot0({cmd.cnt_rd_req, cmd.cnt_rd_ord, cmd.scan_step}))

endmodule

// ===== test/tb.sv =====
// self-checking testbench for symbol_frequency_sorter_unit
// depends on sfs_pkg and the rtl of the symbol frequency sorter
`timescale 1ns / 1ps

module tb;
   import sfs_pkg::*;

   localparam int SYMS      = 128;
   localparam int RUN_LIMIT = 3_000_000;

   typedef struct {
      logic [1:0] opcode;
      logic [7:0] symbol;
      logic [6:0] rank;
      bit         wait_idle;
   } req_item_t;

   typedef struct {
      logic [1:0]  status;
      logic [6:0]  ranked_symbol;
      logic [31:0] symbol_count;
      logic [31:0] total_count;
      logic [7:0]  distinct_symbols;
   } rsp_item_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic [7:0]  req_symbol;
   logic [6:0]  req_rank;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_ranked_symbol;
   logic [31:0] rsp_symbol_count;
   logic [31:0] rsp_total_count;
   logic [7:0]  rsp_distinct_symbols;

   req_item_t pending_reqs[$];
   rsp_item_t expected_rsps[$];

   // predictor state
   logic [31:0] hist[SYMS];
   logic [6:0]  rank_table[SYMS];
   logic [31:0] hist_total;
   logic [7:0]  hist_distinct;
   bit          ranks_valid;

   int  fail_count = 0;
   int  rsp_seen   = 0;
   int  cycle_count = 0;
   bit  req_taken  = 0;
   bit  burst_mode = 0;
   int  req_gap    = 0;
   int  rsp_gap    = 0;
   int  hold_left  = 0;
   bit  hold_done  = 0;

   symbol_frequency_sorter_unit i_dut (.*);

   // clock
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (burst_mode || r < 13) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // rank all symbols by ascending count, ties in symbol order, keep nonzero
   function automatic void rank_symbols();
      int ord[SYMS];
      int j, t, n;
      for (int i = 0; i < SYMS; i++) ord[i] = i;
      for (int i = 1; i < SYMS; i++) begin
         j = i;
         while (j > 0 && hist[ord[j]] < hist[ord[j-1]]) begin
            t = ord[j]; ord[j] = ord[j-1]; ord[j-1] = t;
            j--;
         end
      end
      n = 0;
      for (int i = 0; i < SYMS; i++) rank_table[i] = '0;
      for (int i = 0; i < SYMS; i++)
         if (hist[ord[i]] != 0) begin
            rank_table[n] = 7'(ord[i]);
            n++;
         end
      ranks_valid = 1;
   endfunction

   function automatic rsp_item_t predict_response(req_item_t q);
      rsp_item_t r;
      logic [6:0] s;
      s = q.symbol[6:0];
      r = '{ST_OK, '0, '0, '0, '0};
      case (q.opcode)
         OP_COUNT: begin
            if (hist[s] == 0) hist_distinct++;
            if (hist[s] != '1) hist[s]++;
            if (hist_total != '1) hist_total++;
            ranks_valid = 0;
            r.ranked_symbol = s;
            r.symbol_count = hist[s];
         end
         OP_SORT: rank_symbols();
         OP_READ: begin
            if (!ranks_valid) r.status = ST_UNSORTED;
            else if (q.rank >= hist_distinct) r.status = ST_RANGE;
            else begin
               r.ranked_symbol = rank_table[q.rank];
               r.symbol_count = hist[rank_table[q.rank]];
            end
         end
         default: begin
            for (int i = 0; i < SYMS; i++) hist[i] = '0;
            hist_total = '0;
            hist_distinct = '0;
            ranks_valid = 0;
         end
      endcase
      r.total_count = hist_total;
      r.distinct_symbols = hist_distinct;
      return r;
   endfunction

   task automatic push_req(logic [1:0] op, logic [7:0] sym, logic [6:0] rk,
                           bit idle_first = 0);
      req_item_t q;
      q.opcode = op;
      q.symbol = sym;
      q.rank = rk;
      q.wait_idle = idle_first;
      pending_reqs.push_back(q);
   endtask

   // one clear, count, sort, read session over a few distinct symbols
   task automatic add_session(int n_syms, bit idle_sort);
      logic [6:0] pool[$];
      int n_counts;
      int n_reads;
      pool.delete();
      for (int i = 0; i < n_syms; i++) pool.push_back(7'($urandom_range(0, SYMS - 1)));
      push_req(OP_CLEAR, 8'($urandom), 7'($urandom));
      n_counts = $urandom_range(n_syms, 30);
      for (int i = 0; i < n_counts; i++) begin
         if ($urandom_range(0, 9) == 0)
            push_req(2'($urandom), 8'($urandom), 7'($urandom));
         else
            push_req(OP_COUNT, {1'($urandom), pool[$urandom_range(0, n_syms - 1)]},
                     7'($urandom));
      end
      if ($urandom_range(0, 3) == 0) push_req(OP_READ, 8'($urandom), 7'($urandom));
      push_req(OP_SORT, 8'($urandom), 7'($urandom), idle_sort);
      n_reads = $urandom_range(2, 10);
      for (int i = 0; i < n_reads; i++) begin
         if ($urandom_range(0, 4) == 0)
            push_req(OP_READ, 8'($urandom), 7'($urandom));
         else
            push_req(OP_READ, 8'($urandom), 7'($urandom_range(0, n_syms + 1)));
      end
   endtask

   // stimulus
   initial begin
      int sessions;
      reset = 1;
      req_valid = 0;
      req_opcode = '0;
      req_symbol = '0;
      req_rank = '0;
      rsp_ready = 0;
      for (int i = 0; i < SYMS; i++) begin
         hist[i] = '0;
         rank_table[i] = '0;
      end
      hist_total = '0;
      hist_distinct = '0;
      ranks_valid = 0;

      // directed: empty table, masking, ties, range and unsorted cases
      push_req(OP_READ, 8'h00, 7'd0);
      push_req(OP_SORT, 8'hff, 7'h7f);
      push_req(OP_READ, 8'h00, 7'd0);
      push_req(OP_COUNT, 8'h00, 7'h7f);
      push_req(OP_COUNT, 8'hff, 7'd0);
      push_req(OP_COUNT, 8'h80, 7'd0);
      push_req(OP_COUNT, 8'h7f, 7'd0);
      push_req(OP_COUNT, 8'h55, 7'd0);
      push_req(OP_COUNT, 8'haa, 7'd0);
      push_req(OP_READ, 8'h00, 7'd0);
      push_req(OP_SORT, 8'h00, 7'd0);
      for (int i = 0; i < 5; i++) push_req(OP_READ, 8'h00, 7'(i));
      push_req(OP_READ, 8'h00, 7'h7f);
      push_req(OP_COUNT, 8'h2a, 7'd0);
      push_req(OP_READ, 8'h00, 7'd0);
      push_req(OP_CLEAR, 8'hff, 7'h7f);
      push_req(OP_READ, 8'h00, 7'd0);
      push_req(OP_SORT, 8'h00, 7'd0);
      push_req(OP_READ, 8'h00, 7'd0);

      // full alphabet once, so the highest rank resolves
      push_req(OP_CLEAR, 8'h00, 7'd0);
      for (int i = 0; i < SYMS; i++) push_req(OP_COUNT, 8'(SYMS - 1 - i), 7'd0);
      for (int i = 0; i < 8; i++) push_req(OP_COUNT, 8'($urandom), 7'd0);
      push_req(OP_SORT, 8'h00, 7'd0);
      push_req(OP_READ, 8'h00, 7'h7f);
      push_req(OP_READ, 8'h00, 7'd0);
      push_req(OP_READ, 8'h00, 7'($urandom));

      // random sessions
      sessions = 0;
      while (pending_reqs.size() < 2000) begin
         add_session($urandom_range(1, 8), sessions == 20);
         sessions++;
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("symbol_frequency_sorter_unit: match");
      else $display("symbol_frequency_sorter_unit: mismatch");
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         if ($urandom_range(0, 199) == 0) burst_mode = ~burst_mode;
         if (req_valid && !req_taken) begin
            // hold the transaction until accepted
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 0;
         end else if (pending_reqs.size() != 0 &&
                      (!pending_reqs[0].wait_idle || expected_rsps.size() == 0)) begin
            req_item_t q;
            q = pending_reqs.pop_front();
            req_valid <= 1;
            req_opcode <= q.opcode;
            req_symbol <= q.symbol;
            req_rank <= q.rank;
            req_gap = pick_gap();
         end else begin
            req_valid <= 0;
         end
      end
   end

   // response ready, with one long hold while requests keep coming
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && rsp_seen == 300) begin
            hold_done = 1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
            rsp_gap = pick_gap();
         end
      end
   end

   // monitor: predict on request, compare on response
   always @(posedge clock) begin
      rsp_item_t e;
      req_item_t q;
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("symbol_frequency_sorter_unit: mismatch");
         $finish;
      end
      req_taken = 0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1;
            q.opcode = req_opcode;
            q.symbol = req_symbol;
            q.rank = req_rank;
            q.wait_idle = 0;
            expected_rsps.push_back(predict_response(q));
         end
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               $error("response transaction with nothing expected");
               fail_count++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status);
                  fail_count++;
               end
               if (rsp_ranked_symbol !== e.ranked_symbol) begin
                  $error("ranked_symbol: expected %0d, got %0d",
                         e.ranked_symbol, rsp_ranked_symbol);
                  fail_count++;
               end
               if (rsp_symbol_count !== e.symbol_count) begin
                  $error("symbol_count: expected %0d, got %0d",
                         e.symbol_count, rsp_symbol_count);
                  fail_count++;
               end
               if (rsp_total_count !== e.total_count) begin
                  $error("total_count: expected %0d, got %0d",
                         e.total_count, rsp_total_count);
                  fail_count++;
               end
               if (rsp_distinct_symbols !== e.distinct_symbols) begin
                  $error("distinct_symbols: expected %0d, got %0d",
                         e.distinct_symbols, rsp_distinct_symbols);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sfs_pkg.sv
rtl/sfs_ctrl.sv
rtl/sfs_datapath.sv
rtl/symbol_frequency_sorter_unit.sv
test/tb.sv
